// ===== rtl/bicubic_image_resize_assert.svh =====
// Assertion macros shared by the resizer RTL
`ifndef BICUBIC_IMAGE_RESIZE_ASSERT_SVH
`define BICUBIC_IMAGE_RESIZE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bir_pkg.sv =====
// Shared widths, types and helpers of the bicubic resizer
package bir_pkg;
  localparam int unsigned PixBits   = 8;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned AddrBits  = 16;
  localparam int unsigned StoreDepth = 65536;
  localparam int unsigned SampBits  = 20;
  localparam int unsigned AccBits   = 26;
  localparam int unsigned OutBits   = 18;

  typedef logic signed [SampBits-1:0] samp_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  localparam acc_t OutLow  = -acc_t'(65536);
  localparam acc_t OutHigh = acc_t'(131071);

  // saturate to the 18-bit output range
  function automatic logic [OutBits-1:0] sat_out(input acc_t v);
    acc_t r;
    r = v;
    if (v < OutLow) r = OutLow;
    if (v > OutHigh) r = OutHigh;
    return r[OutBits-1:0];
  endfunction
endpackage

// ===== rtl/bir_ram.sv =====
// Generic single-port RAM with registered read
module bir_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/bir_cubic.sv =====
// Catmull-Rom cubic, Horner form, one shared multiplier over three steps
module bir_cubic (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  bir_pkg::samp_t                 p_i [4],
  input  logic [bir_pkg::FracBits-1:0]   t_i,
  output logic                           done_o,
  output bir_pkg::acc_t                  f_o
);
  typedef enum logic [1:0] {C_IDLE, C_A, C_B, C_C} cstate_e;

  cstate_e               state_q;
  bir_pkg::acc_t         b_q, c_q, p1_q, u_q;
  logic [bir_pkg::FracBits-1:0] t_q;
  bir_pkg::acc_t         p0, p1, p2, p3, opnd;
  logic signed [bir_pkg::AccBits+bir_pkg::FracBits:0] prod, rnd16, rnd17;

  assign p0 = bir_pkg::acc_t'(p_i[0]);
  assign p1 = bir_pkg::acc_t'(p_i[1]);
  assign p2 = bir_pkg::acc_t'(p_i[2]);
  assign p3 = bir_pkg::acc_t'(p_i[3]);

  // u_q holds a during the first step
  assign opnd  = u_q;
  assign prod  = opnd * $signed({1'b0, t_q});
  assign rnd16 = prod + (43'sd1 <<< (bir_pkg::FracBits - 1));
  assign rnd17 = prod + (43'sd1 <<< bir_pkg::FracBits);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            u_q   <= 3 * (p1 - p2) + p3 - p0;
            b_q   <= 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c_q   <= p2 - p0;
            p1_q  <= p1;
            t_q   <= t_i;
            state_q <= C_A;
          end
        end
        C_A: begin
          u_q     <= b_q + rnd16[bir_pkg::AccBits+15:16];
          state_q <= C_B;
        end
        C_B: begin
          u_q     <= c_q + rnd16[bir_pkg::AccBits+15:16];
          state_q <= C_C;
        end
        C_C: begin
          f_o     <= p1_q + rnd17[bir_pkg::AccBits+16:17];
          done_o  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/bicubic_image_resize.sv =====
// Bicubic (Catmull-Rom) grayscale frame resizer, top level
// Load item (tuser 0): written to the frame store; the block stays idle, so the input stays ready.
// Output request: 16 store reads (one port, registered read) plus five cubics on the shared
// multiplier; pass-through takes a single store read.
// First request of each output frame first runs the two 24-step step divisions.
// Reset (async, active low) clears counters and positions; sizes return to 256x256 each.
// The frame store is not cleared: unwritten pixels read as anything.
`include "bicubic_image_resize_assert.svh"
module bicubic_image_resize (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tuser,   // [0] mode
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] pixel_out, [23:18] zero
  output logic        m_axis_tlast    // frame_last
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_FETCH, S_CAPT, S_ROWC, S_COLC, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0, REG_SRC_H = 2'd1, REG_DST_W = 2'd2, REG_DST_H = 2'd3
  } reg_e;

  state_e state_q;

  logic [8:0]  src_w_q, src_h_q;
  logic [10:0] dst_w_q, dst_h_q;
  logic [16:0] load_q;
  logic [9:0]  row_q, col_q;
  logic [24:0] pos_x_q, pos_y_q, step_x_q, step_y_q;

  // divider
  logic        div_y_q;
  logic [4:0]  div_cnt_q;
  logic [23:0] div_num_q;
  logic [10:0] div_rem_q;
  logic [11:0] div_trial;

  // window walk
  logic [1:0]  fr_q, fk_q;
  logic        pass_q;
  bir_pkg::samp_t win_q [4];
  bir_pkg::samp_t rowv_q [4];
  bir_pkg::samp_t cub_p [4];
  logic [bir_pkg::FracBits-1:0] cub_t;
  logic        cub_start, cub_done;
  bir_pkg::acc_t cub_f;

  logic [17:0] out_q;
  logic        last_q;

  // sizes clamped to their legal ranges
  logic [8:0]  sw, sh;
  logic [10:0] dw, dh;
  logic [16:0] frame;

  assign sw = (src_w_q == 9'd0) ? 9'd1 : ((src_w_q > 9'd256) ? 9'd256 : src_w_q);
  assign sh = (src_h_q == 9'd0) ? 9'd1 : ((src_h_q > 9'd256) ? 9'd256 : src_h_q);
  assign dw = (dst_w_q == 11'd0) ? 11'd1 : ((dst_w_q > 11'd1024) ? 11'd1024 : dst_w_q);
  assign dh = (dst_h_q == 11'd0) ? 11'd1 : ((dst_h_q > 11'd1024) ? 11'd1024 : dst_h_q);
  assign frame = 17'(sw * sh);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, out_q};
  assign m_axis_tlast  = last_q;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // load address, wrapping at the frame size
  logic [16:0] load_eff, load_nxt;
  assign load_eff = (load_q >= frame) ? 17'd0 : load_q;
  assign load_nxt = (load_eff + 17'd1 >= frame) ? 17'd0 : load_eff + 17'd1;

  // window addresses with border replication
  logic signed [9:0] cx_raw, ry_raw;
  logic [7:0]  cx, ry;
  logic [16:0] rd_addr;
  assign cx_raw = $signed({2'b0, pos_x_q[23:16]}) + $signed({8'b0, fk_q}) - 10'sd1;
  assign ry_raw = $signed({2'b0, pos_y_q[23:16]}) + $signed({8'b0, fr_q}) - 10'sd1;
  always_comb begin
    if (pass_q) begin
      cx = col_q[7:0];
      ry = row_q[7:0];
    end else begin
      if (cx_raw < 0) cx = 8'd0;
      else if (cx_raw > $signed({1'b0, sw - 9'd1})) cx = 8'(sw - 9'd1);
      else cx = cx_raw[7:0];
      if (ry_raw < 0) ry = 8'd0;
      else if (ry_raw > $signed({1'b0, sh - 9'd1})) ry = 8'(sh - 9'd1);
      else ry = ry_raw[7:0];
    end
  end
  assign rd_addr = 17'(ry * sw) + {9'd0, cx};

  logic                         ram_we;
  logic [bir_pkg::AddrBits-1:0] ram_addr;
  logic [bir_pkg::PixBits-1:0]  ram_rdata;
  assign ram_we   = in_acc && !s_axis_tuser;
  assign ram_addr = ram_we ? load_eff[bir_pkg::AddrBits-1:0]
                           : rd_addr[bir_pkg::AddrBits-1:0];

  bir_ram #(.Width(bir_pkg::PixBits), .Depth(bir_pkg::StoreDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s_axis_tdata),
    .rdata_o (ram_rdata)
  );

  bir_pkg::samp_t pix_s;
  assign pix_s = bir_pkg::samp_t'({ram_rdata, 8'd0});

  // row cubic starts on the fourth sample, column cubic on the fourth row
  always_comb begin
    cub_p = win_q;
    cub_t = pos_x_q[15:0];
    cub_start = 1'b0;
    if (state_q == S_CAPT && fk_q == 2'd3 && !pass_q) begin
      cub_p[3] = pix_s;
      cub_start = 1'b1;
    end else if (state_q == S_ROWC && cub_done && fr_q == 2'd3) begin
      cub_p = rowv_q;
      cub_p[3] = bir_pkg::samp_t'(cub_f);
      cub_t = pos_y_q[15:0];
      cub_start = 1'b1;
    end
  end

  bir_cubic u_cubic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cub_start),
    .p_i     (cub_p),
    .t_i     (cub_t),
    .done_o  (cub_done),
    .f_o     (cub_f)
  );

  assign div_trial = {div_rem_q, div_num_q[23]};

  // result ready this cycle
  logic          fin;
  bir_pkg::acc_t fin_v;
  assign fin   = (state_q == S_CAPT && pass_q) || (state_q == S_COLC && cub_done);
  assign fin_v = pass_q ? bir_pkg::acc_t'(pix_s) : cub_f;

  logic [10:0] col_n, row_n;
  assign col_n = {1'b0, col_q} + 11'd1;
  assign row_n = {1'b0, row_q} + 11'd1;

  logic        wrap;
  assign wrap = ({1'b0, row_q} >= dh) || ({1'b0, col_q} >= dw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      src_w_q   <= 9'd256;
      src_h_q   <= 9'd256;
      dst_w_q   <= 11'd256;
      dst_h_q   <= 11'd256;
      load_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
      div_y_q   <= 1'b0;
      div_cnt_q <= '0;
      fr_q      <= '0;
      fk_q      <= '0;
      pass_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (reg_e'(cfg_index_i))
          REG_SRC_W: src_w_q <= cfg_data_i[8:0];
          REG_SRC_H: src_h_q <= cfg_data_i[8:0];
          REG_DST_W: dst_w_q <= cfg_data_i;
          REG_DST_H: dst_h_q <= cfg_data_i;
          default:   ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!s_axis_tuser) begin
              load_q <= load_nxt;
            end else begin
              fr_q   <= '0;
              fk_q   <= '0;
              pass_q <= ({2'b0, sw} == dw) && ({2'b0, sh} == dh);
              if (wrap || (row_q == '0 && col_q == '0)) begin
                // new output frame: recompute the steps
                row_q     <= '0;
                col_q     <= '0;
                pos_x_q   <= '0;
                pos_y_q   <= '0;
                div_y_q   <= 1'b0;
                div_cnt_q <= '0;
                div_rem_q <= '0;
                div_num_q <= {8'(sw - 9'd1), 16'd0};
                state_q   <= S_DIV;
              end else begin
                state_q <= S_FETCH;
              end
            end
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          div_num_q <= {div_num_q[22:0], (div_trial >= {1'b0, div_y_q ? dh : dw})};
          div_rem_q <= (div_trial >= {1'b0, div_y_q ? dh : dw})
                       ? 11'(div_trial - {1'b0, div_y_q ? dh : dw})
                       : div_trial[10:0];
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'd23) begin
            div_cnt_q <= '0;
            div_rem_q <= '0;
            if (!div_y_q) begin
              step_x_q  <= {1'b0, div_num_q[22:0],
                            (div_trial >= {1'b0, dw})};
              div_y_q   <= 1'b1;
              div_num_q <= {8'(sh - 9'd1), 16'd0};
            end else begin
              step_y_q <= {1'b0, div_num_q[22:0],
                           (div_trial >= {1'b0, dh})};
              state_q  <= S_FETCH;
            end
          end
        end
        S_FETCH: state_q <= S_CAPT;
        S_CAPT: begin
          win_q[fk_q] <= pix_s;
          fk_q <= fk_q + 2'd1;
          if (pass_q) state_q <= S_OUT;
          else if (fk_q == 2'd3) state_q <= S_ROWC;
          else state_q <= S_FETCH;
        end
        S_ROWC: begin
          if (cub_done) begin
            rowv_q[fr_q] <= bir_pkg::samp_t'(cub_f);
            fr_q <= fr_q + 2'd1;
            state_q <= (fr_q == 2'd3) ? S_COLC : S_FETCH;
          end
        end
        S_COLC: begin
          if (cub_done) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      if (fin) begin
        out_q   <= bir_pkg::sat_out(fin_v);
        last_q  <= ({1'b0, row_q} == dh - 11'd1) && ({1'b0, col_q} == dw - 11'd1);
        if (col_n >= dw) begin
          col_q   <= '0;
          pos_x_q <= '0;
          pos_y_q <= pos_y_q + step_y_q;
          row_q   <= (row_n >= dh) ? 10'd0 : row_n[9:0];
        end else begin
          col_q   <= col_n[9:0];
          pos_x_q <= pos_x_q + step_x_q;
        end
      end
    end
  end

  `BIR_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `BIR_ASSERT_NOW(a_cub_done_state, cub_done, (state_q == S_ROWC) || (state_q == S_COLC), "stray cubic result")
  `BIR_ASSERT_NEXT(a_out_release, out_acc, s_axis_tready && !m_axis_tvalid, "not idle after result taken")
  `BIR_ASSERT_NOW(a_cub_start_idle, cub_start, !cub_done || (state_q == S_ROWC), "cubic restarted while busy")

endmodule

// ===== tb/sv/bicubic_image_resize_tb.sv =====
// Self-checking testbench for the bicubic frame resizer
module bicubic_image_resize_tb;
  import bir_pkg::*;

  localparam int unsigned WatchLimit = 5000;  // idle cycles before giving up
  localparam int unsigned LongHold   = 400;   // receiver hold-off, cycles
  localparam int unsigned DrainWait  = 120;   // covers a full request plus step division

  typedef enum logic [1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1,
    RegDstWidth  = 2'd2,
    RegDstHeight = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ModeLoad    = 1'b0,
    ModeRequest = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    RowCfg,
    RowLoad,
    RowReq
  } row_kind_e;

  typedef struct {
    row_kind_e      kind;
    reg_idx_e       idx;
    logic [10:0]    data;
    logic [7:0]     pix;
    bit             typed;
    logic [17:0]    pix_out;
    logic           last;
  } stim_row_t;

  typedef struct {
    logic [OutBits-1:0] pix_out;
    logic               last;
  } out_pix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  bicubic_image_resize i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the frame store, counters and sizes
  // ---------------------------------------------------------------------------
  logic [7:0]  pix_mem [StoreDepth];
  int unsigned raw_sw = 256, raw_sh = 256, raw_dw = 256, raw_dh = 256;
  int unsigned wr_ptr = 0, row_cnt = 0, col_cnt = 0;
  longint      acc_x = 0, acc_y = 0, inc_x = 0, inc_y = 0;

  out_pix_t    pending_px [$];
  int          n_fail = 0;
  int unsigned n_out = 0;
  bit          hold_req = 1'b0;

  function automatic int unsigned sat_u(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor((v + half) / 2^s): round half up
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                     longint t);
    longint a, b, c, u;
    a = 3 * (p1 - p2) + p3 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c = p2 - p0;
    u = b + rnd_shift(a * t, FracBits);
    u = c + rnd_shift(u * t, FracBits);
    return p1 + rnd_shift(u * t, FracBits + 1);
  endfunction

  function automatic longint clamp_pos(longint v, int unsigned n);
    if (v < 0) return 0;
    if (v > longint'(n) - 1) return longint'(n) - 1;
    return v;
  endfunction

  function automatic longint px_at(int unsigned w, longint r, longint c);
    return longint'(pix_mem[r * w + c]) <<< 8;
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [10:0] val);
    case (idx)
      RegSrcWidth:  raw_sw = val[8:0];
      RegSrcHeight: raw_sh = val[8:0];
      RegDstWidth:  raw_dw = val;
      default:      raw_dh = val;
    endcase
  endfunction

  // works out the result, if any, of one accepted item and advances the state
  function automatic bit resize_item(logic mode, logic [7:0] pix, output out_pix_t res);
    int unsigned sw, sh, dw, dh, frm;
    longint      v, ix, iy, fx, fy;
    longint      rowv [4];
    longint      win [4];
    sw  = sat_u(raw_sw, 1, 256);
    sh  = sat_u(raw_sh, 1, 256);
    dw  = sat_u(raw_dw, 1, 1024);
    dh  = sat_u(raw_dh, 1, 1024);
    frm = sw * sh;
    res = '{default: '0};
    if (mode == ModeLoad) begin
      if (wr_ptr >= frm) wr_ptr = 0;
      pix_mem[wr_ptr] = pix;
      wr_ptr++;
      if (wr_ptr >= frm) wr_ptr = 0;
      return 1'b0;
    end
    if (row_cnt >= dh || col_cnt >= dw) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    if (row_cnt == 0 && col_cnt == 0) begin
      inc_x = (longint'(sw - 1) <<< FracBits) / dw;
      inc_y = (longint'(sh - 1) <<< FracBits) / dh;
      acc_x = 0;
      acc_y = 0;
    end
    if (sw == dw && sh == dh) begin
      v = px_at(sw, row_cnt, col_cnt);
    end else begin
      ix = acc_x >>> FracBits;
      iy = acc_y >>> FracBits;
      fx = acc_x & ((longint'(1) <<< FracBits) - 1);
      fy = acc_y & ((longint'(1) <<< FracBits) - 1);
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++)
          win[k] = px_at(sw, clamp_pos(iy + r - 1, sh), clamp_pos(ix + k - 1, sw));
        rowv[r] = catmull(win[0], win[1], win[2], win[3], fx);
      end
      v = catmull(rowv[0], rowv[1], rowv[2], rowv[3], fy);
    end
    if (v < -65536) v = -65536;
    if (v > 131071) v = 131071;
    res.pix_out = v[OutBits-1:0];
    res.last    = (row_cnt == dh - 1) && (col_cnt == dw - 1);
    col_cnt++;
    acc_x += inc_x;
    if (col_cnt >= dw) begin
      col_cnt = 0;
      acc_x = 0;
      row_cnt++;
      acc_y += inc_y;
      if (row_cnt >= dh) row_cnt = 0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_item(logic mode, logic [7:0] pix, bit typed = 1'b0,
                           out_pix_t typed_res = '{default: '0});
    out_pix_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    if (resize_item(mode, pix, res)) begin
      // directed rows with a readable answer are checked against the typed value
      pending_px.push_back(typed ? typed_res : res);
    end
  endtask

  // registers change only with the block drained and quiet
  task automatic write_reg(reg_idx_e idx, logic [10:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
    write_reg(RegSrcWidth, 11'(sw));
    write_reg(RegSrcHeight, 11'(sh));
    write_reg(RegDstWidth, 11'(dw));
    write_reg(RegDstHeight, 11'(dh));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes at random times, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall_pct;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) stall_pct = 25 * $urandom_range(0, 3);
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_pix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result pix_out=%h last=%b", $time,
                 m_axis_tdata[OutBits-1:0], m_axis_tlast);
        n_fail++;
      end else begin
        want = pending_px.pop_front();
        if (m_axis_tdata[OutBits-1:0] !== want.pix_out) begin
          $display("%0t: pix_out expected %h got %h", $time, want.pix_out,
                   m_axis_tdata[OutBits-1:0]);
          n_fail++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: frame_last expected %b got %b", $time, want.last, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // watchdog: cycles in which nothing at all is accepted
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_px.size());
      $display("FAIL bicubic_image_resize");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table: pass-through 2x2, 1x1 output, then a 2x2 to 4x3 upscale
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [22] = '{
    '{RowCfg,  RegSrcWidth,  11'd2, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowCfg,  RegSrcHeight, 11'd2, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowCfg,  RegDstWidth,  11'd2, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowCfg,  RegDstHeight, 11'd2, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowLoad, RegSrcWidth,  11'd0, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowLoad, RegSrcWidth,  11'd0, 8'hFF, 1'b0, 18'h0,     1'b0},
    '{RowLoad, RegSrcWidth,  11'd0, 8'h80, 1'b0, 18'h0,     1'b0},
    '{RowLoad, RegSrcWidth,  11'd0, 8'h01, 1'b0, 18'h0,     1'b0},
    // equal sizes: pixels come back shifted into 8 fraction bits
    '{RowReq,  RegSrcWidth,  11'd0, 8'hFF, 1'b1, 18'h00000, 1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b1, 18'h0FF00, 1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h5A, 1'b1, 18'h08000, 1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'hA5, 1'b1, 18'h00100, 1'b1},
    // 1x1 output: position 0, so the top-left pixel, every item last
    '{RowCfg,  RegDstWidth,  11'd1, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowCfg,  RegDstHeight, 11'd1, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b1, 18'h00000, 1'b1},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b1, 18'h00000, 1'b1},
    '{RowCfg,  RegDstWidth,  11'd4, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowCfg,  RegDstHeight, 11'd3, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b0, 18'h0,     1'b0},
    '{RowReq,  RegSrcWidth,  11'd0, 8'h00, 1'b0, 18'h0,     1'b0}
  };

  initial begin
    int unsigned n_items, sw, sh, dw, dh, frm, n_req, phase;
    n_items = 0;
    phase   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        RowCfg:  write_reg(dir_tab[i].idx, dir_tab[i].data);
        RowLoad: send_item(ModeLoad, dir_tab[i].pix);
        default: send_item(ModeRequest, dir_tab[i].pix, dir_tab[i].typed,
                           '{dir_tab[i].pix_out, dir_tab[i].last});
      endcase
    end

    // random phases: new sizes, a full frame load, then mostly requests
    while (n_items < 500 || n_out < 60) begin
      case ($urandom_range(0, 9))
        0, 1: begin  // pass-through
          sw = $urandom_range(2, 9); sh = $urandom_range(2, 9); dw = sw; dh = sh;
        end
        2: begin     // widest source, sizes out of range on the short side
          sw = ($urandom_range(0, 1) != 0) ? 256 : 511; sh = $urandom_range(0, 2);
          dw = $urandom_range(1, 12); dh = $urandom_range(1, 4);
        end
        3: begin     // tallest source
          sw = $urandom_range(0, 2); sh = ($urandom_range(0, 1) != 0) ? 256 : 400;
          dw = $urandom_range(1, 4); dh = $urandom_range(1, 12);
        end
        4: begin     // output size extremes, zero and beyond the top saturate
          sw = $urandom_range(2, 6); sh = $urandom_range(2, 6);
          dw = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 1024 : 2047);
          dh = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 1024 : 2047);
        end
        default: begin
          sw = $urandom_range(1, 9); sh = $urandom_range(1, 9);
          dw = $urandom_range(1, 16); dh = $urandom_range(1, 16);
        end
      endcase
      set_sizes(sw, sh, dw, dh);
      // a whole frame of loads covers every entry whatever the write pointer
      frm = sat_u(sw, 1, 256) * sat_u(sh, 1, 256);
      repeat (frm) begin
        send_item(ModeLoad, 8'($urandom));
        n_items++;
      end
      if (phase == 2) hold_req = 1'b1;  // long hold-off with the sender still busy
      n_req = $urandom_range(1, 40);
      while (n_req > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(ModeLoad, 8'($urandom));
        end else begin
          send_item(ModeRequest, 8'($urandom));
          n_req--;
        end
        n_items++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (n_fail == 0 && pending_px.size() == 0) begin
      $display("PASS bicubic_image_resize");
    end else begin
      $display("FAIL bicubic_image_resize");
    end
    $finish;
  end

endmodule

// ===== bicubic_image_resize.f =====
+incdir+rtl
rtl/bir_pkg.sv
rtl/bir_ram.sv
rtl/bir_cubic.sv
rtl/bicubic_image_resize.sv
tb/sv/bicubic_image_resize_tb.sv
